// File: rtl/core/rtkt_pkg.sv
// Shared types and constants for the ranked top-k table.
package rtkt_pkg;

  // Default number of ranks the table holds.
  localparam int TABLE_DEPTH_DEF = 16;

  // Largest values of the narrow result fields.
  localparam int RANK_MAX  = 15;
  localparam int COUNT_MAX = 31;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef struct packed {
    logic [23:0] score;
    logic [15:0] seconds;
    logic [7:0]  grid;
    logic [31:0] player;
  } entry_t;

endpackage

// File: rtl/core/rtkt_ifs.sv
// Valid/ready channel interfaces for the ranked top-k table.
interface rtkt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] entry_score;
  logic [15:0] elapsed_seconds;
  logic [7:0]  grid_size;
  logic [31:0] player_tag;
  logic [3:0]  read_rank;

  modport source (output valid, op, entry_score, elapsed_seconds, grid_size, player_tag,
                  read_rank, input ready);
  modport sink   (input valid, op, entry_score, elapsed_seconds, grid_size, player_tag,
                  read_rank, output ready);
endinterface

interface rtkt_out_if;
  logic        valid;
  logic        ready;
  logic        kept;
  logic [3:0]  placed_rank;
  logic [4:0]  entry_count;
  logic        read_valid;
  logic [23:0] read_score;
  logic [15:0] read_seconds;
  logic [7:0]  read_grid;
  logic [31:0] read_player;

  modport source (output valid, kept, placed_rank, entry_count, read_valid, read_score,
                  read_seconds, read_grid, read_player, input ready);
  modport sink   (input valid, kept, placed_rank, entry_count, read_valid, read_score,
                  read_seconds, read_grid, read_player, output ready);
endinterface

// File: rtl/core/rtkt_store.sv
// Entry memory: one write port, one read port with registered read data.
module rtkt_store #(
  parameter int DEPTH = rtkt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  rtkt_pkg::entry_t       wr_data,
  input  logic [AW-1:0]          rd_addr,
  output rtkt_pkg::entry_t       rd_data
);

  rtkt_pkg::entry_t mem [DEPTH];
  rtkt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/rtkt_cmp.sv
// Rank comparator: true when the candidate ranks strictly above the stored entry.
module rtkt_cmp (
  input  rtkt_pkg::entry_t cand,
  input  rtkt_pkg::entry_t stored,
  output logic             beats
);

  // Higher score wins; on equal score the shorter time wins. Exact ties lose,
  // so a new entry lands after an identical one.
  assign beats = (cand.score > stored.score) ||
                 ((cand.score == stored.score) && (cand.seconds < stored.seconds));

endmodule

// File: rtl/core/ranked_top_k_table.sv
// Top level of the ranked top-k table: sequencer, entry memory and comparator.
//
// Keeps up to TABLE_DEPTH entries in rank order (higher score first, then lower
// time) and takes one transaction at a time: insert, read by rank, or clear.
// Every input transaction yields exactly one result transaction. An insert walks
// the table from the worst held entry upward through one shared comparator,
// moving each beaten entry down one rank as it goes, one entry per cycle. An
// insert that stops at an entry it does not beat goes through acceptance, the
// first memory read, one compare per entry it passes plus the stopping compare,
// the final write and the result. An insert that beats every held entry needs
// no stopping compare. With the table empty an insert goes straight to the
// final write and the result, and an insert rejected by a full table skips the
// write. A read goes through the memory read and a fetch to the result, or
// straight to the result if the rank is empty; a clear or an unused op code
// goes straight to the result. The walk length is set by the single read port
// of the entry memory and the single comparator. The input is not ready while a
// transaction is in progress or its result waits to be taken. When the table is
// full and the new entry does not beat the worst one, the insert is rejected
// with kept low and the table is left as it was. Rank and count fields saturate
// at 15 and 31 when TABLE_DEPTH exceeds what they can show.
module ranked_top_k_table #(
  parameter int TABLE_DEPTH = rtkt_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rtkt_in_if.sink     in_ch,
  rtkt_out_if.source  out_ch
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ISSUE  = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_PLACE  = 6'b001000,
    ST_FETCH  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  rtkt_pkg::op_t      op_r, op_nxt;
  rtkt_pkg::entry_t   new_r, new_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;    // next address to read
  logic [AW-1:0]      cmp_r, cmp_nxt;    // address whose data is being compared
  logic [AW-1:0]      pos_r, pos_nxt;    // rank where the new entry goes

  logic               kept_r, kept_nxt;
  logic [3:0]         rank_r, rank_nxt;
  logic               rvalid_r, rvalid_nxt;
  rtkt_pkg::entry_t   rentry_r, rentry_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  rtkt_pkg::entry_t   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  rtkt_pkg::entry_t   mem_rdata;
  logic               beats;

  logic [31:0]        below_w;           // rank just below the compared entry
  logic [31:0]        pos_w;
  logic [31:0]        held_w;

  rtkt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  rtkt_cmp u_cmp (
    .cand   (new_r),
    .stored (mem_rdata),
    .beats  (beats)
  );

  assign below_w = 32'(cmp_r) + 32'd1;
  assign pos_w   = 32'(pos_r);
  assign held_w  = 32'(held_r);

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    op_nxt     = op_r;
    new_nxt    = new_r;
    idx_nxt    = idx_r;
    cmp_nxt    = cmp_r;
    pos_nxt    = pos_r;
    kept_nxt   = kept_r;
    rank_nxt   = rank_r;
    rvalid_nxt = rvalid_r;
    rentry_nxt = rentry_r;
    mem_we     = 1'b0;
    mem_waddr  = AW'(below_w);
    mem_wdata  = mem_rdata;
    mem_raddr  = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt        = rtkt_pkg::op_t'(in_ch.op);
          new_nxt.score   = in_ch.entry_score;
          new_nxt.seconds = in_ch.elapsed_seconds;
          new_nxt.grid    = in_ch.grid_size;
          new_nxt.player  = in_ch.player_tag;
          kept_nxt      = 1'b0;
          rank_nxt      = 4'd0;
          rvalid_nxt    = 1'b0;
          rentry_nxt    = '0;
          case (rtkt_pkg::op_t'(in_ch.op))
            rtkt_pkg::OP_INSERT: begin
              if (held_r == '0) begin
                pos_nxt   = '0;
                state_nxt = ST_PLACE;
              end else begin
                idx_nxt   = AW'(held_r - CW'(1));
                state_nxt = ST_ISSUE;
              end
            end
            rtkt_pkg::OP_READ: begin
              if (32'(in_ch.read_rank) < held_w) begin
                idx_nxt   = AW'(in_ch.read_rank);
                state_nxt = ST_ISSUE;
              end else begin
                state_nxt = ST_RESULT;
              end
            end
            rtkt_pkg::OP_CLEAR: begin
              held_nxt  = '0;
              state_nxt = ST_RESULT;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      ST_ISSUE: begin
        cmp_nxt   = idx_r;
        idx_nxt   = idx_r - AW'(1);
        state_nxt = (op_r == rtkt_pkg::OP_READ) ? ST_FETCH : ST_SCAN;
      end

      ST_SCAN: begin
        // The read of the next higher rank is already in flight, so the walk
        // keeps one entry per cycle while the new entry keeps winning.
        if (beats) begin
          if (below_w < 32'(TABLE_DEPTH)) begin
            mem_we = 1'b1;
          end
          if (cmp_r == '0) begin
            pos_nxt   = '0;
            state_nxt = ST_PLACE;
          end else begin
            cmp_nxt = cmp_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end else if (below_w < 32'(TABLE_DEPTH)) begin
          pos_nxt   = AW'(below_w);
          state_nxt = ST_PLACE;
        end else begin
          // Table full and the new entry does not beat the worst one.
          state_nxt = ST_RESULT;
        end
      end

      ST_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = new_r;
        if (held_w < 32'(TABLE_DEPTH)) begin
          held_nxt = held_r + CW'(1);
        end
        kept_nxt  = 1'b1;
        rank_nxt  = (pos_w > 32'(rtkt_pkg::RANK_MAX)) ? 4'(rtkt_pkg::RANK_MAX) : pos_w[3:0];
        state_nxt = ST_RESULT;
      end

      ST_FETCH: begin
        rvalid_nxt = 1'b1;
        rentry_nxt = mem_rdata;
        state_nxt  = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    new_r    <= new_nxt;
    idx_r    <= idx_nxt;
    cmp_r    <= cmp_nxt;
    pos_r    <= pos_nxt;
    kept_r   <= kept_nxt;
    rank_r   <= rank_nxt;
    rvalid_r <= rvalid_nxt;
    rentry_r <= rentry_nxt;
  end

  // The input is taken only when no transaction is in progress.
  assign in_ch.ready = (state_r == ST_IDLE);

  // The result is held in registers until the downstream side takes it.
  assign out_ch.valid        = (state_r == ST_RESULT);
  assign out_ch.kept         = kept_r;
  assign out_ch.placed_rank  = rank_r;
  assign out_ch.entry_count  = (held_w > 32'(rtkt_pkg::COUNT_MAX)) ?
                               5'(rtkt_pkg::COUNT_MAX) : held_w[4:0];
  assign out_ch.read_valid   = rvalid_r;
  assign out_ch.read_score   = rentry_r.score;
  assign out_ch.read_seconds = rentry_r.seconds;
  assign out_ch.read_grid    = rentry_r.grid;
  assign out_ch.read_player  = rentry_r.player;

endmodule
